[hw/rtl/wou_pkg.sv]
// ----------------------------------------------------------------------------
// wou_pkg
// Shared types, constants and helper functions for the wheel odometry block.
// ----------------------------------------------------------------------------
package wou_pkg;

   localparam int CORDIC_STEPS = 16;
   localparam int ATAN_ENTRIES = 24;
   localparam int STEP_W       = $clog2(ATAN_ENTRIES);

   localparam int CHUNK_W = 16;
   localparam int MAC_A_W = 40;
   localparam int MAC_B_W = CHUNK_W + 1;
   localparam int ACC_W   = 64;
   localparam int WIDE_W  = 38;
   localparam int TRIG_W  = 34;
   localparam int DEG_W   = 34;
   localparam int MOD_W   = 50;
   localparam int MOD_SHIFT = 14;

   localparam logic [31:0] DEG_TO_RAD_Q32 = 32'd74961353;
   localparam logic [31:0] RAD_TO_DEG_Q16 = 32'd3754935;

   localparam logic signed [MOD_W-1:0] TWO_PI_Q32 = 50'sd26986075409;
   localparam logic signed [MOD_W-1:0] PI_Q32     = 50'sd13493037705;
   localparam logic signed [MOD_W-1:0] MOD_TOP    = TWO_PI_Q32 <<< MOD_SHIFT;

   localparam logic signed [TRIG_W-1:0] PI_Q30          = 34'sd3373259426;
   localparam logic signed [TRIG_W-1:0] HALF_PI_Q30     = 34'sd1686629713;
   localparam logic signed [TRIG_W-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;

   localparam logic [15:0] TURN_GAIN_RESET = 16'd2791;

   localparam logic [1:0] CSR_X_DRIFT   = 2'd0;
   localparam logic [1:0] CSR_Y_DRIFT   = 2'd1;
   localparam logic [1:0] CSR_TURN_GAIN = 2'd2;

   localparam logic CMD_UPDATE = 1'b0;
   localparam logic CMD_HOME   = 1'b1;

   typedef struct packed {
      logic               command;
      logic signed [31:0] back_left_deg;
      logic signed [31:0] front_left_deg;
      logic signed [31:0] back_right_deg;
      logic signed [31:0] front_right_deg;
   } req_type;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] heading_deg;
      logic signed [31:0] travel_total;
   } rsp_type;

   typedef struct packed {
      logic en;
      logic clr;
      logic hi;
   } mac_ctl_type;

   function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
      logic signed [31:0] r;
      if (v > 40'sh007fffffff) begin
         r = 32'sh7fffffff;
      end else if (v < -40'sh0080000000) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   function automatic logic signed [WIDE_W-1:0] rnd24(input logic signed [ACC_W-1:0] a);
      logic signed [ACC_W-1:0] t;
      t = a + 64'sd8388608;
      return t[WIDE_W+23:24];
   endfunction

   function automatic logic signed [WIDE_W-1:0] rnd16(input logic signed [ACC_W-1:0] a);
      logic signed [ACC_W-1:0] t;
      t = a + 64'sd32768;
      return t[WIDE_W+15:16];
   endfunction

   function automatic logic signed [TRIG_W-1:0] rnd30(input logic signed [ACC_W-1:0] a);
      logic signed [ACC_W-1:0] t;
      t = a + 64'sd536870912;
      return t[TRIG_W+29:30];
   endfunction

   function automatic logic signed [TRIG_W-1:0] atan_q30(input logic [STEP_W-1:0] idx);
      logic signed [TRIG_W-1:0] r;
      unique case (idx)
         5'd0:  r = 34'sd843314856;
         5'd1:  r = 34'sd497837829;
         5'd2:  r = 34'sd263043836;
         5'd3:  r = 34'sd133525158;
         5'd4:  r = 34'sd67021686;
         5'd5:  r = 34'sd33543515;
         5'd6:  r = 34'sd16775850;
         5'd7:  r = 34'sd8388437;
         5'd8:  r = 34'sd4194282;
         5'd9:  r = 34'sd2097149;
         5'd10: r = 34'sd1048575;
         5'd11: r = 34'sd524287;
         5'd12: r = 34'sd262143;
         5'd13: r = 34'sd131071;
         5'd14: r = 34'sd65535;
         5'd15: r = 34'sd32767;
         5'd16: r = 34'sd16383;
         5'd17: r = 34'sd8191;
         5'd18: r = 34'sd4095;
         5'd19: r = 34'sd2047;
         5'd20: r = 34'sd1023;
         5'd21: r = 34'sd511;
         5'd22: r = 34'sd255;
         5'd23: r = 34'sd127;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

[hw/rtl/wou_mac.sv]
// ----------------------------------------------------------------------------
// wou_mac
// Shared multiply-accumulate: signed operand times a 16-bit chunk, optionally
// weighted by 2^16, added into a 64-bit accumulator.
// ----------------------------------------------------------------------------
module wou_mac import wou_pkg::*; (
   input  logic                     clock,
   input  mac_ctl_type              ctl,
   input  logic signed [MAC_A_W-1:0] a,
   input  logic signed [MAC_B_W-1:0] b,
   output logic signed [ACC_W-1:0]   acc
);

   logic signed [MAC_A_W+MAC_B_W-1:0] prod;
   logic signed [ACC_W-1:0]           term;
   logic signed [ACC_W-1:0]           base;
   logic signed [ACC_W-1:0]           acc_ff;
   logic signed [ACC_W-1:0]           acc_in;

   assign prod = a * b;

   always_comb begin
      term = {{(ACC_W-MAC_A_W-MAC_B_W){prod[MAC_A_W+MAC_B_W-1]}}, prod};
      if (ctl.hi) begin
         term = term <<< CHUNK_W;
      end
      base   = ctl.clr ? '0 : acc_ff;
      acc_in = ctl.en ? base + term : acc_ff;
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   assign acc = acc_ff;

endmodule

[hw/rtl/wou_cordic.sv]
// ----------------------------------------------------------------------------
// wou_cordic
// Iterative angle reduction (modulo 2*pi by shifted subtraction), quadrant
// fold and CORDIC rotation. Produces cos and sin in Q30.
// ----------------------------------------------------------------------------
module wou_cordic import wou_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic signed [31:0]       angle,
   output logic                     done,
   output logic signed [TRIG_W-1:0] cos_q30,
   output logic signed [TRIG_W-1:0] sin_q30
);

   localparam logic [2:0] P_IDLE = 3'd0;
   localparam logic [2:0] P_MOD  = 3'd1;
   localparam logic [2:0] P_WRAP = 3'd2;
   localparam logic [2:0] P_FOLD = 3'd3;
   localparam logic [2:0] P_ROT  = 3'd4;
   localparam logic [2:0] P_NEG  = 3'd5;

   localparam int CNT_W = $clog2(MOD_SHIFT + 1);

   logic [2:0]               phase_ff, phase_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic [STEP_W-1:0]        i_ff, i_in;
   logic                     done_ff, done_in;
   logic                     neg_ff, neg_in;
   logic signed [MOD_W-1:0]  v_ff, v_in;
   logic signed [MOD_W-1:0]  m_ff, m_in;
   logic signed [TRIG_W-1:0] x_ff, x_in;
   logic signed [TRIG_W-1:0] y_ff, y_in;
   logic signed [TRIG_W-1:0] z_ff, z_in;
   logic signed [TRIG_W-1:0] cos_ff, cos_in;
   logic signed [TRIG_W-1:0] sin_ff, sin_in;

   logic signed [MOD_W-1:0]  ang_ext;
   logic signed [MOD_W-1:0]  diff;
   logic signed [MOD_W-1:0]  vq;
   logic signed [TRIG_W-1:0] zt;
   logic signed [TRIG_W-1:0] xs;
   logic signed [TRIG_W-1:0] ys;
   logic signed [TRIG_W-1:0] at;

   always_comb begin
      ang_ext = {{(MOD_W-48){angle[31]}}, angle, 16'h0000};
      diff    = v_ff - m_ff;
      vq      = v_ff >>> 2;
      zt      = vq[TRIG_W-1:0];
      xs      = x_ff >>> i_ff;
      ys      = y_ff >>> i_ff;
      at      = atan_q30(i_ff);

      phase_in = phase_ff;
      cnt_in   = cnt_ff;
      i_in     = i_ff;
      done_in  = 1'b0;
      neg_in   = neg_ff;
      v_in     = v_ff;
      m_in     = m_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      z_in     = z_ff;
      cos_in   = cos_ff;
      sin_in   = sin_ff;

      unique case (phase_ff)
         P_IDLE: begin
            if (start) begin
               v_in     = angle[31] ? ang_ext + MOD_TOP : ang_ext;
               m_in     = MOD_TOP;
               cnt_in   = CNT_W'(MOD_SHIFT);
               phase_in = P_MOD;
            end
         end
         P_MOD: begin
            if (!diff[MOD_W-1]) begin
               v_in = diff;
            end
            m_in = m_ff >>> 1;
            if (cnt_ff == '0) begin
               phase_in = P_WRAP;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         P_WRAP: begin
            if (v_ff >= PI_Q32) begin
               v_in = v_ff - TWO_PI_Q32;
            end
            phase_in = P_FOLD;
         end
         P_FOLD: begin
            priority if (zt > HALF_PI_Q30) begin
               z_in   = zt - PI_Q30;
               neg_in = 1'b1;
            end else if (zt < -HALF_PI_Q30) begin
               z_in   = zt + PI_Q30;
               neg_in = 1'b1;
            end else begin
               z_in   = zt;
               neg_in = 1'b0;
            end
            x_in     = CORDIC_GAIN_Q30;
            y_in     = '0;
            i_in     = '0;
            phase_in = P_ROT;
         end
         P_ROT: begin
            if (!z_ff[TRIG_W-1]) begin
               x_in = x_ff - ys;
               y_in = y_ff + xs;
               z_in = z_ff - at;
            end else begin
               x_in = x_ff + ys;
               y_in = y_ff - xs;
               z_in = z_ff + at;
            end
            if (i_ff == STEP_W'(CORDIC_STEPS - 1)) begin
               phase_in = P_NEG;
            end else begin
               i_in = i_ff + 1'b1;
            end
         end
         P_NEG: begin
            cos_in   = neg_ff ? -x_ff : x_ff;
            sin_in   = neg_ff ? -y_ff : y_ff;
            done_in  = 1'b1;
            phase_in = P_IDLE;
         end
         default: begin
            phase_in = P_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= P_IDLE;
         done_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         done_ff  <= done_in;
      end
      cnt_ff <= cnt_in;
      i_ff   <= i_in;
      neg_ff <= neg_in;
      v_ff   <= v_in;
      m_ff   <= m_in;
      x_ff   <= x_in;
      y_ff   <= y_in;
      z_ff   <= z_in;
      cos_ff <= cos_in;
      sin_ff <= sin_in;
   end

   assign done    = done_ff;
   assign cos_q30 = cos_ff;
   assign sin_q30 = sin_ff;

endmodule

[hw/rtl/wheel_odometry_update_top.sv]
// ----------------------------------------------------------------------------
// wheel_odometry_update_top
// Dead-reckoning pose update for a four-wheel differential drive.
//
// req_* beat: command plus four absolute wheel angles (degrees, Q24.8).
//   command = update: wheel deltas against the last readings give travel
//   and heading steps; pose advances along cos/sin of the new heading.
//   command = home: pose and distance clear, last readings are kept.
// rsp_* beat: one per request, x, y, heading in degrees, total travel.
// csr_*: write-only x_drift, y_drift, turn_gain; write only while idle.
// Sequencing: one request is in work at a time; req_ready is high only
//   when idle, so the next accept waits until the result is loaded. A home
//   request skips straight to the degree conversion and output states. The
//   cost of an update is set by the shared multiply-accumulate (eleven chunk
//   products) and the iterative CORDIC (15 reduction steps plus one
//   rotation per step).
// The result sits in an output register: the next request is accepted while
// it waits; a stalled receiver only holds the sequencer in its last state.
// Reset clears the pose, the last readings and restores the register
// defaults (turn_gain = 2791).
// ----------------------------------------------------------------------------
module wheel_odometry_update_top import wou_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        csr_write_en,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   localparam logic [4:0] S_IDLE   = 5'd0;
   localparam logic [4:0] S_LM0    = 5'd1;
   localparam logic [4:0] S_LM1    = 5'd2;
   localparam logic [4:0] S_RM0    = 5'd3;
   localparam logic [4:0] S_RM1    = 5'd4;
   localparam logic [4:0] S_RRAD   = 5'd5;
   localparam logic [4:0] S_GAIN   = 5'd6;
   localparam logic [4:0] S_HEAD   = 5'd7;
   localparam logic [4:0] S_HEAD2  = 5'd8;
   localparam logic [4:0] S_CSTART = 5'd9;
   localparam logic [4:0] S_WAITC  = 5'd10;
   localparam logic [4:0] S_XM0    = 5'd11;
   localparam logic [4:0] S_XM1    = 5'd12;
   localparam logic [4:0] S_YM0    = 5'd13;
   localparam logic [4:0] S_YM1    = 5'd14;
   localparam logic [4:0] S_DM0    = 5'd15;
   localparam logic [4:0] S_DM1    = 5'd16;
   localparam logic [4:0] S_OUT    = 5'd17;

   logic [4:0]               state_ff, state_in;
   logic                     home_ff, home_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_type                  rsp_data_ff, rsp_data_in;
   logic signed [31:0]       x_drift_ff, x_drift_in;
   logic signed [31:0]       y_drift_ff, y_drift_in;
   logic [15:0]              gain_ff, gain_in;
   logic signed [31:0]       last_bl_ff, last_bl_in;
   logic signed [31:0]       last_fl_ff, last_fl_in;
   logic signed [31:0]       last_br_ff, last_br_in;
   logic signed [31:0]       last_fr_ff, last_fr_in;
   logic signed [31:0]       heading_ff, heading_in;
   logic signed [31:0]       dist_ff, dist_in;
   logic signed [31:0]       x_ff, x_in;
   logic signed [31:0]       y_ff, y_in;
   logic signed [DEG_W-1:0]  ldeg_ff, ldeg_in;
   logic signed [DEG_W-1:0]  rdeg_ff, rdeg_in;
   logic signed [WIDE_W-1:0] lrad_ff, lrad_in;
   logic signed [WIDE_W-1:0] rrad_ff, rrad_in;
   logic signed [31:0]       st_ff, st_in;
   logic signed [WIDE_W-1:0] rot_ff, rot_in;
   logic signed [TRIG_W-1:0] xprod_ff, xprod_in;
   logic signed [TRIG_W-1:0] yprod_ff, yprod_in;

   mac_ctl_type               mac_ctl;
   logic signed [MAC_A_W-1:0] mac_a;
   logic signed [MAC_B_W-1:0] mac_b;
   logic signed [ACC_W-1:0]   mac_acc;

   logic                     cor_start;
   logic                     cor_done;
   logic signed [TRIG_W-1:0] cor_cos;
   logic signed [TRIG_W-1:0] cor_sin;

   logic                     req_fire;
   logic                     rsp_free;
   logic signed [WIDE_W:0]   rad_diff;
   logic signed [WIDE_W:0]   rad_sum;
   logic signed [WIDE_W:0]   rad_half;
   logic signed [WIDE_W-1:0] deg_wide;

   wou_mac u_mac (
      .clock (clock),
      .ctl   (mac_ctl),
      .a     (mac_a),
      .b     (mac_b),
      .acc   (mac_acc)
   );

   wou_cordic u_cordic (
      .clock   (clock),
      .reset   (reset),
      .start   (cor_start),
      .angle   (heading_ff),
      .done    (cor_done),
      .cos_q30 (cor_cos),
      .sin_q30 (cor_sin)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign cor_start = (state_ff == S_CSTART);

   always_comb begin
      rad_diff = {lrad_ff[WIDE_W-1], lrad_ff} - {rrad_ff[WIDE_W-1], rrad_ff};
      rad_sum  = {lrad_ff[WIDE_W-1], lrad_ff} + {rrad_ff[WIDE_W-1], rrad_ff};
      rad_half = rad_sum >>> 1;
      deg_wide = rnd16(mac_acc);
   end

   // multiply-accumulate operand selection
   always_comb begin
      mac_ctl = '0;
      mac_a   = '0;
      mac_b   = '0;
      unique case (state_ff)
         S_LM0: begin
            mac_ctl = '{en: 1'b1, clr: 1'b1, hi: 1'b0};
            mac_a   = {{(MAC_A_W-DEG_W){ldeg_ff[DEG_W-1]}}, ldeg_ff};
            mac_b   = {1'b0, DEG_TO_RAD_Q32[15:0]};
         end
         S_LM1: begin
            mac_ctl = '{en: 1'b1, clr: 1'b0, hi: 1'b1};
            mac_a   = {{(MAC_A_W-DEG_W){ldeg_ff[DEG_W-1]}}, ldeg_ff};
            mac_b   = {1'b0, DEG_TO_RAD_Q32[31:16]};
         end
         S_RM0: begin
            mac_ctl = '{en: 1'b1, clr: 1'b1, hi: 1'b0};
            mac_a   = {{(MAC_A_W-DEG_W){rdeg_ff[DEG_W-1]}}, rdeg_ff};
            mac_b   = {1'b0, DEG_TO_RAD_Q32[15:0]};
         end
         S_RM1: begin
            mac_ctl = '{en: 1'b1, clr: 1'b0, hi: 1'b1};
            mac_a   = {{(MAC_A_W-DEG_W){rdeg_ff[DEG_W-1]}}, rdeg_ff};
            mac_b   = {1'b0, DEG_TO_RAD_Q32[31:16]};
         end
         S_GAIN: begin
            mac_ctl = '{en: 1'b1, clr: 1'b1, hi: 1'b0};
            mac_a   = {{(MAC_A_W-WIDE_W-1){rad_diff[WIDE_W]}}, rad_diff};
            mac_b   = {1'b0, gain_ff};
         end
         S_XM0: begin
            mac_ctl = '{en: 1'b1, clr: 1'b1, hi: 1'b0};
            mac_a   = {{(MAC_A_W-TRIG_W){cor_cos[TRIG_W-1]}}, cor_cos};
            mac_b   = {1'b0, st_ff[15:0]};
         end
         S_XM1: begin
            mac_ctl = '{en: 1'b1, clr: 1'b0, hi: 1'b1};
            mac_a   = {{(MAC_A_W-TRIG_W){cor_cos[TRIG_W-1]}}, cor_cos};
            mac_b   = {st_ff[31], st_ff[31:16]};
         end
         S_YM0: begin
            mac_ctl = '{en: 1'b1, clr: 1'b1, hi: 1'b0};
            mac_a   = {{(MAC_A_W-TRIG_W){cor_sin[TRIG_W-1]}}, cor_sin};
            mac_b   = {1'b0, st_ff[15:0]};
         end
         S_YM1: begin
            mac_ctl = '{en: 1'b1, clr: 1'b0, hi: 1'b1};
            mac_a   = {{(MAC_A_W-TRIG_W){cor_sin[TRIG_W-1]}}, cor_sin};
            mac_b   = {st_ff[31], st_ff[31:16]};
         end
         S_DM0: begin
            mac_ctl = '{en: 1'b1, clr: 1'b1, hi: 1'b0};
            mac_a   = {{(MAC_A_W-32){heading_ff[31]}}, heading_ff};
            mac_b   = {1'b0, RAD_TO_DEG_Q16[15:0]};
         end
         S_DM1: begin
            mac_ctl = '{en: 1'b1, clr: 1'b0, hi: 1'b1};
            mac_a   = {{(MAC_A_W-32){heading_ff[31]}}, heading_ff};
            mac_b   = {1'b0, RAD_TO_DEG_Q16[31:16]};
         end
         default: begin
            mac_ctl = '0;
         end
      endcase
   end

   // sequencer and datapath registers
   always_comb begin
      state_in     = state_ff;
      home_in      = home_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      x_drift_in   = x_drift_ff;
      y_drift_in   = y_drift_ff;
      gain_in      = gain_ff;
      last_bl_in   = last_bl_ff;
      last_fl_in   = last_fl_ff;
      last_br_in   = last_br_ff;
      last_fr_in   = last_fr_ff;
      heading_in   = heading_ff;
      dist_in      = dist_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      ldeg_in      = ldeg_ff;
      rdeg_in      = rdeg_ff;
      lrad_in      = lrad_ff;
      rrad_in      = rrad_ff;
      st_in        = st_ff;
      rot_in       = rot_ff;
      xprod_in     = xprod_ff;
      yprod_in     = yprod_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_write_en) begin
         unique case (csr_index)
            CSR_X_DRIFT:   x_drift_in = csr_wdata;
            CSR_Y_DRIFT:   y_drift_in = csr_wdata;
            CSR_TURN_GAIN: gain_in    = csr_wdata[15:0];
            default: begin
            end
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               if (req_data.command == CMD_HOME) begin
                  heading_in = '0;
                  dist_in    = '0;
                  x_in       = '0;
                  y_in       = '0;
                  home_in    = 1'b1;
                  state_in   = S_DM0;
               end else begin
                  ldeg_in = ({{2{req_data.back_left_deg[31]}}, req_data.back_left_deg}
                             - {{2{last_bl_ff[31]}}, last_bl_ff})
                          + ({{2{req_data.front_left_deg[31]}}, req_data.front_left_deg}
                             - {{2{last_fl_ff[31]}}, last_fl_ff});
                  rdeg_in = ({{2{req_data.back_right_deg[31]}}, req_data.back_right_deg}
                             - {{2{last_br_ff[31]}}, last_br_ff})
                          + ({{2{req_data.front_right_deg[31]}}, req_data.front_right_deg}
                             - {{2{last_fr_ff[31]}}, last_fr_ff});
                  last_bl_in = req_data.back_left_deg;
                  last_fl_in = req_data.front_left_deg;
                  last_br_in = req_data.back_right_deg;
                  last_fr_in = req_data.front_right_deg;
                  home_in    = 1'b0;
                  state_in   = S_LM0;
               end
            end
         end
         S_LM0:  state_in = S_LM1;
         S_LM1:  state_in = S_RM0;
         S_RM0: begin
            lrad_in  = rnd24(mac_acc);
            state_in = S_RM1;
         end
         S_RM1:  state_in = S_RRAD;
         S_RRAD: begin
            rrad_in  = rnd24(mac_acc);
            state_in = S_GAIN;
         end
         S_GAIN: begin
            st_in    = sat32({rad_half[WIDE_W], rad_half});
            state_in = S_HEAD;
         end
         S_HEAD: begin
            rot_in   = rnd16(mac_acc);
            dist_in  = sat32({{8{dist_ff[31]}}, dist_ff} + {{8{st_ff[31]}}, st_ff});
            state_in = S_HEAD2;
         end
         S_HEAD2: begin
            heading_in = sat32({{8{heading_ff[31]}}, heading_ff}
                             + {{(40-WIDE_W){rot_ff[WIDE_W-1]}}, rot_ff});
            state_in   = S_CSTART;
         end
         S_CSTART: state_in = S_WAITC;
         S_WAITC: begin
            if (cor_done) begin
               state_in = S_XM0;
            end
         end
         S_XM0:  state_in = S_XM1;
         S_XM1:  state_in = S_YM0;
         S_YM0: begin
            xprod_in = rnd30(mac_acc);
            state_in = S_YM1;
         end
         S_YM1: begin
            x_in = sat32({{8{x_ff[31]}}, x_ff}
                       + {{(40-TRIG_W){xprod_ff[TRIG_W-1]}}, xprod_ff}
                       + {{8{x_drift_ff[31]}}, x_drift_ff});
            state_in = S_DM0;
         end
         S_DM0: begin
            yprod_in = rnd30(mac_acc);
            state_in = S_DM1;
         end
         S_DM1: begin
            if (!home_ff) begin
               y_in = sat32({{8{y_ff[31]}}, y_ff}
                          + {{(40-TRIG_W){yprod_ff[TRIG_W-1]}}, yprod_ff}
                          + {{8{y_drift_ff[31]}}, y_drift_ff});
            end
            state_in = S_OUT;
         end
         S_OUT: begin
            if (rsp_free) begin
               rsp_data_in.pos_x        = x_ff;
               rsp_data_in.pos_y        = y_ff;
               rsp_data_in.heading_deg  = sat32({{(40-WIDE_W){deg_wide[WIDE_W-1]}},
                                                 deg_wide});
               rsp_data_in.travel_total = dist_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         home_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         x_drift_ff   <= '0;
         y_drift_ff   <= '0;
         gain_ff      <= TURN_GAIN_RESET;
         last_bl_ff   <= '0;
         last_fl_ff   <= '0;
         last_br_ff   <= '0;
         last_fr_ff   <= '0;
         heading_ff   <= '0;
         dist_ff      <= '0;
         x_ff         <= '0;
         y_ff         <= '0;
      end else begin
         state_ff     <= state_in;
         home_ff      <= home_in;
         rsp_valid_ff <= rsp_valid_in;
         x_drift_ff   <= x_drift_in;
         y_drift_ff   <= y_drift_in;
         gain_ff      <= gain_in;
         last_bl_ff   <= last_bl_in;
         last_fl_ff   <= last_fl_in;
         last_br_ff   <= last_br_in;
         last_fr_ff   <= last_fr_in;
         heading_ff   <= heading_in;
         dist_ff      <= dist_in;
         x_ff         <= x_in;
         y_ff         <= y_in;
      end
      rsp_data_ff <= rsp_data_in;
      ldeg_ff     <= ldeg_in;
      rdeg_ff     <= rdeg_in;
      lrad_ff     <= lrad_in;
      rrad_ff     <= rrad_in;
      st_ff       <= st_in;
      rot_ff      <= rot_in;
      xprod_ff    <= xprod_in;
      yprod_ff    <= yprod_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_ready)
      else $error("request accepted while a beat is in work");

   a_cordic_done_waited: assert property (@(posedge clock) disable iff (reset)
      cor_done |-> (state_ff == S_WAITC))
      else $error("cordic finished outside the wait state");

   a_home_clears_pose: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_data.command == CMD_HOME)
      |=> (x_ff == '0 && y_ff == '0 && heading_ff == '0 && dist_ff == '0))
      else $error("home did not clear the pose");

   a_result_loaded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT && rsp_free) |=> (rsp_valid_ff && state_ff == S_IDLE))
      else $error("result beat not loaded on completion");

endmodule

[bench/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for wheel_odometry_update_top. A queue-fed driver sends
// encoder and home beats with random gaps. A bit-exact pose predictor runs on
// every accepted beat. A monitor with random stalls compares each result
// beat, field by field, against the oldest predicted pose. The run steps
// through several drift and turn gain settings, the extremes among them.
// ----------------------------------------------------------------------------
module testbench;
   import wou_pkg::*;

   localparam int     CYCLE_LIMIT   = 2_000_000;
   localparam int     PHASE_ITEMS   = 205;
   localparam int     DEG           = 256;
   localparam logic [1:0] CSR_SPARE = 2'd3;

   localparam longint DEG2RAD_Q32   = 64'sd74961353;
   localparam longint RAD2DEG_Q16   = 64'sd3754935;
   localparam longint FULL_TURN_Q32 = 64'sd26986075409;
   localparam longint HALF_TURN_Q32 = 64'sd13493037705;
   localparam longint HALF_TURN_Q30 = 64'sd3373259426;
   localparam longint QUARTER_Q30   = 64'sd1686629713;
   localparam longint ROT_GAIN_Q30  = 64'sd652032874;

   logic        clock        = 1'b0;
   logic        reset        = 1'b1;
   logic        req_valid    = 1'b0;
   logic        req_ready;
   req_type     req_data     = '0;
   logic        rsp_valid;
   logic        rsp_ready    = 1'b0;
   rsp_type     rsp_data;
   logic        csr_write_en = 1'b0;
   logic [1:0]  csr_index    = CSR_X_DRIFT;
   logic [31:0] csr_wdata    = '0;

   wheel_odometry_update_top u_top (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always #5 clock = ~clock;

   // arctangent steps, Q30, floor truncated
   longint arctan_tab [0:23] = '{
      64'sd843314856, 64'sd497837829, 64'sd263043836, 64'sd133525158,
      64'sd67021686, 64'sd33543515, 64'sd16775850, 64'sd8388437,
      64'sd4194282, 64'sd2097149, 64'sd1048575, 64'sd524287,
      64'sd262143, 64'sd131071, 64'sd65535, 64'sd32767,
      64'sd16383, 64'sd8191, 64'sd4095, 64'sd2047,
      64'sd1023, 64'sd511, 64'sd255, 64'sd127
   };

   // predictor state and register copy
   logic signed [31:0] last_deg [4];
   logic signed [31:0] heading_acc;
   logic signed [31:0] travel_acc;
   logic signed [31:0] x_acc;
   logic signed [31:0] y_acc;
   logic signed [31:0] drift_x;
   logic signed [31:0] drift_y;
   logic [15:0]        gain_reg;

   req_type pending_reqs [$];
   rsp_type expected_poses [$];
   rsp_type want_pose;

   logic signed [31:0] odo [4];
   bit  quiet_mode = 1'b0;
   int  send_gap = 0;
   int  stall_left = 0;
   int  error_count = 0;
   int  results_checked = 0;
   int  reqs_sent = 0;
   int  homes_sent = 0;
   int  settings_used = 0;
   int  cycle_count = 0;

   function automatic logic signed [31:0] clamp32(input longint v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   function automatic void heading_trig(input logic signed [31:0] ang,
                                        output longint c, output longint s);
      longint r, x, y, z, nx;
      bit     flip;
      int     i;
      r = (longint'(ang) * 64'sd65536) % FULL_TURN_Q32;
      if (r < 0) r += FULL_TURN_Q32;
      if (r >= HALF_TURN_Q32) r -= FULL_TURN_Q32;
      z = r >>> 2;
      flip = 1'b0;
      if (z > QUARTER_Q30) begin
         z -= HALF_TURN_Q30;
         flip = 1'b1;
      end else if (z < -QUARTER_Q30) begin
         z += HALF_TURN_Q30;
         flip = 1'b1;
      end
      x = ROT_GAIN_Q30;
      y = 0;
      for (i = 0; i < CORDIC_STEPS && i < 24; i++) begin
         if (z >= 0) begin
            nx = x - (y >>> i);
            y  = y + (x >>> i);
            z  = z - arctan_tab[i];
         end else begin
            nx = x + (y >>> i);
            y  = y - (x >>> i);
            z  = z + arctan_tab[i];
         end
         x = nx;
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
   endfunction

   function automatic rsp_type predict_pose(input req_type it);
      rsp_type            o;
      logic signed [31:0] now [4];
      longint             ldeg, rdeg, lrad, rrad, step, rot, cs, sn;
      logic signed [31:0] st;
      int                 i;
      if (it.command == CMD_HOME) begin
         heading_acc = '0;
         travel_acc  = '0;
         x_acc       = '0;
         y_acc       = '0;
      end else begin
         now[0] = it.back_left_deg;
         now[1] = it.front_left_deg;
         now[2] = it.back_right_deg;
         now[3] = it.front_right_deg;
         ldeg = (longint'(now[0]) - longint'(last_deg[0]))
              + (longint'(now[1]) - longint'(last_deg[1]));
         rdeg = (longint'(now[2]) - longint'(last_deg[2]))
              + (longint'(now[3]) - longint'(last_deg[3]));
         for (i = 0; i < 4; i++) last_deg[i] = now[i];
         lrad = (ldeg * DEG2RAD_Q32 + 64'sd8388608) >>> 24;
         rrad = (rdeg * DEG2RAD_Q32 + 64'sd8388608) >>> 24;
         step = (lrad + rrad) >>> 1;
         st = clamp32(step);
         travel_acc = clamp32(longint'(travel_acc) + longint'(st));
         rot = ((lrad - rrad) * longint'({48'd0, gain_reg}) + 64'sd32768) >>> 16;
         heading_acc = clamp32(longint'(heading_acc) + rot);
         heading_trig(heading_acc, cs, sn);
         x_acc = clamp32(longint'(x_acc) + ((longint'(st) * cs + 64'sd536870912) >>> 30)
                         + longint'(drift_x));
         y_acc = clamp32(longint'(y_acc) + ((longint'(st) * sn + 64'sd536870912) >>> 30)
                         + longint'(drift_y));
      end
      o.pos_x        = x_acc;
      o.pos_y        = y_acc;
      o.heading_deg  = clamp32((longint'(heading_acc) * RAD2DEG_Q16 + 64'sd32768) >>> 16);
      o.travel_total = travel_acc;
      return o;
   endfunction

   function automatic int pick_gap();
      int r;
      if (quiet_mode) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 20);
      return $urandom_range(30, 150);
   endfunction

   function automatic req_type make_req(input logic cmd, input logic signed [31:0] bl,
                                        input logic signed [31:0] fl,
                                        input logic signed [31:0] br,
                                        input logic signed [31:0] fr);
      req_type it;
      it.command         = cmd;
      it.back_left_deg   = bl;
      it.front_left_deg  = fl;
      it.back_right_deg  = br;
      it.front_right_deg = fr;
      return it;
   endfunction

   // mostly smooth motion from the current wheel angles, some homes and jumps
   function automatic req_type make_random_req();
      req_type it;
      int      pick, lim, fwd, turn;
      pick = $urandom_range(0, 99);
      it = make_req(CMD_UPDATE, $urandom, $urandom, $urandom, $urandom);
      if (pick < 8) begin
         it.command = CMD_HOME;
      end else if (pick >= 22) begin
         case ($urandom_range(0, 3))
            0:       lim = 1 << 8;
            1:       lim = 1 << 12;
            2:       lim = 1 << 16;
            default: lim = 1 << 20;
         endcase
         fwd  = int'($urandom_range(0, 2 * lim)) - lim;
         turn = int'($urandom_range(0, lim)) - lim / 2;
         it.back_left_deg   = odo[0] + fwd + turn + int'($urandom_range(0, 15));
         it.front_left_deg  = odo[1] + fwd + turn + int'($urandom_range(0, 15));
         it.back_right_deg  = odo[2] + fwd - turn + int'($urandom_range(0, 15));
         it.front_right_deg = odo[3] + fwd - turn + int'($urandom_range(0, 15));
      end
      return it;
   endfunction

   function automatic logic [31:0] small_drift();
      return int'($urandom_range(0, 131072)) - 65536;
   endfunction

   task automatic push_item(input req_type it);
      pending_reqs.push_back(it);
      reqs_sent++;
      if (it.command == CMD_HOME) begin
         homes_sent++;
      end else begin
         odo[0] = it.back_left_deg;
         odo[1] = it.front_left_deg;
         odo[2] = it.back_right_deg;
         odo[3] = it.front_right_deg;
      end
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [31:0] val);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= val;
      @(posedge clock);
      csr_write_en <= 1'b0;
      case (idx)
         CSR_X_DRIFT:   drift_x  = val;
         CSR_Y_DRIFT:   drift_y  = val;
         CSR_TURN_GAIN: gain_reg = val[15:0];
         default: ;
      endcase
   endtask

   task automatic set_regs(input logic [31:0] xd, input logic [31:0] yd,
                           input logic [15:0] gain);
      write_csr(CSR_X_DRIFT, xd);
      write_csr(CSR_Y_DRIFT, yd);
      write_csr(CSR_TURN_GAIN, {16'd0, gain});
      settings_used++;
      @(negedge clock);
   endtask

   task automatic wait_idle();
      while (pending_reqs.size() != 0 || req_valid || expected_poses.size() != 0)
         @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %h got %h", $time, name, want, got);
         error_count++;
      end
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid   <= 1'b0;
         send_gap     = 0;
         for (int i = 0; i < 4; i++) last_deg[i] = '0;
         heading_acc  = '0;
         travel_acc   = '0;
         x_acc        = '0;
         y_acc        = '0;
         drift_x      = '0;
         drift_y      = '0;
         gain_reg     = TURN_GAIN_RESET;
      end else begin
         if (req_valid && req_ready) begin
            expected_poses.push_back(predict_pose(req_data));
            send_gap = pick_gap();
         end
         if (!req_valid || req_ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (pending_reqs.size() != 0) begin
               req_valid <= 1'b1;
               req_data  <= pending_reqs.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_poses.size() == 0) begin
               $display("%0t: result beat with nothing outstanding, got %h", $time, rsp_data);
               error_count++;
            end else begin
               want_pose = expected_poses.pop_front();
               check_field("pos_x", want_pose.pos_x, rsp_data.pos_x);
               check_field("pos_y", want_pose.pos_y, rsp_data.pos_y);
               check_field("heading_deg", want_pose.heading_deg, rsp_data.heading_deg);
               check_field("travel_total", want_pose.travel_total, rsp_data.travel_total);
               results_checked++;
            end
            stall_left = pick_gap();
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout, %0d results outstanding", $time, expected_poses.size());
         $display("end of test: mismatches");
         $finish;
      end
   end

   initial begin
      for (int i = 0; i < 4; i++) odo[i] = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // unused index must be ignored
      write_csr(CSR_SPARE, $urandom);
      set_regs('0, '0, TURN_GAIN_RESET);

      // directed: first update from zero, home keeps readings, turns, jumps
      push_item(make_req(CMD_UPDATE, 360 * DEG, 360 * DEG, 360 * DEG, 360 * DEG));
      push_item(make_req(CMD_HOME, $urandom, $urandom, $urandom, $urandom));
      push_item(make_req(CMD_UPDATE, odo[0] + 360 * DEG, odo[1] + 360 * DEG,
                         odo[2] + 360 * DEG, odo[3] + 360 * DEG));
      for (int k = 0; k < 6; k++)
         push_item(make_req(CMD_UPDATE, odo[0] + 3000 * DEG, odo[1] + 3000 * DEG,
                            odo[2] - 3000 * DEG, odo[3] - 3000 * DEG));
      push_item(make_req(CMD_UPDATE, odo[0] - 500 * DEG, odo[1] - 500 * DEG,
                         odo[2] - 500 * DEG, odo[3] - 500 * DEG));
      push_item(make_req(CMD_UPDATE, 32'sh7fffffff, 32'sh7fffffff,
                         32'sh7fffffff, 32'sh7fffffff));
      push_item(make_req(CMD_UPDATE, 32'sh80000000, 32'sh80000000,
                         32'sh80000000, 32'sh80000000));
      push_item(make_req(CMD_UPDATE, 32'sh7fffffff, 32'sh7fffffff,
                         32'sh7fffffff, 32'sh7fffffff));
      push_item(make_req(CMD_UPDATE, 32'sh7fffffff, 32'sh7fffffff,
                         32'sh80000000, 32'sh80000000));
      push_item(make_req(CMD_UPDATE, 32'sh80000000, 32'sh80000000,
                         32'sh7fffffff, 32'sh7fffffff));
      push_item(make_req(CMD_UPDATE, '0, '0, '0, '0));
      push_item(make_req(CMD_HOME, '0, '0, '0, '0));
      push_item(make_req(CMD_HOME, 32'sh7fffffff, 32'sh80000000,
                         32'sh7fffffff, 32'sh80000000));
      push_item(make_req(CMD_UPDATE, odo[0] + 1, odo[1] + 1, odo[2] + 1, odo[3] + 1));
      push_item(make_req(CMD_UPDATE, odo[0] - 1, odo[1] - 1, odo[2] - 1, odo[3] - 1));
      wait_idle();

      for (int p = 0; p < 8; p++) begin
         quiet_mode = 1'b0;
         case (p)
            0: set_regs('0, '0, 16'hffff);
            1: set_regs(32'h7fffffff, 32'h80000000, 16'd0);
            2: set_regs(small_drift(), small_drift(), TURN_GAIN_RESET);
            3: set_regs(32'h80000000, 32'h7fffffff, 16'($urandom_range(0, 65535)));
            4: set_regs($urandom, $urandom, 16'($urandom_range(0, 65535)));
            5: begin
               set_regs('0, '0, TURN_GAIN_RESET);
               quiet_mode = 1'b1;
            end
            6: set_regs(small_drift(), small_drift(), 16'd1);
            default: set_regs($urandom, small_drift(), 16'($urandom_range(1000, 8000)));
         endcase
         for (int n = 0; n < PHASE_ITEMS; n++) push_item(make_random_req());
         wait_idle();
      end

      repeat (60) @(negedge clock);
      $display("covered %0d requests (%0d home) over %0d register settings",
               reqs_sent, homes_sent, settings_used);
      $display("%0d result beats compared, %0d mismatches, %0d left outstanding",
               results_checked, error_count, expected_poses.size());
      if (error_count == 0 && expected_poses.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
